[rtl/core/pib_pkg.sv]
// Shared types and constants for the palette index builder.
// Used by pib_ctrl, pib_datapath and palette_index_builder; depends on nothing.

package pib_pkg;

   // Palette size and the widths that follow from it.
   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PALETTE_ENTRIES);

   // Fixed widths of the word fields.
   localparam int COMP_W  = 8;
   localparam int COLOR_W = 3 * COMP_W;
   localparam int INDEX_W = 8;
   localparam int USED_W  = 9;

   typedef struct packed {
      logic              first_pixel;
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
   } pib_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] color_index;
      logic               new_entry;
      logic [USED_W-1:0]  entries_used;
      logic               palette_usable;
   } pib_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } pib_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic overflowed;
      logic hit;
      logic exhausted;
   } pib_status_type;

endpackage

[rtl/core/pib_ctrl.sv]
// Sequencer of the palette index builder: accept, palette scan and result hand-off.
// Depends on pib_pkg.

module pib_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pib_pkg::pib_status_type status,
   output pib_pkg::pib_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic decided;
   logic slot_free;

   always_comb begin
      decided   = status.overflowed || status.hit || status.exhausted;
      slot_free = !rsp_valid_ff || rsp_ready;
      // No word is taken while reset is held.
      req_ready = (state_ff == ST_IDLE) && !reset;

      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      state_in   = state_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Once the answer is known the scan stops and holds until the
            // output register can take the word.
            if (!decided) begin
               cmd.scan = 1'b1;
            end else if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/pib_datapath.sv]
// Datapath of the palette index builder: palette memory, entry count, overflow
// flag, sequential compare and the result register. Depends on pib_pkg.

module pib_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  pib_pkg::pib_req_type    req_data,
   input  pib_pkg::pib_cmd_type    cmd,
   output pib_pkg::pib_status_type status,
   output pib_pkg::pib_rsp_type    rsp_data
);

   logic [pib_pkg::COLOR_W-1:0] palette_mem [pib_pkg::PALETTE_ENTRIES];

   logic [pib_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [pib_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic [pib_pkg::CNT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic [pib_pkg::ADDR_W-1:0]  rd_idx_ff;
   logic [pib_pkg::COLOR_W-1:0] rd_data_ff;
   pib_pkg::pib_rsp_type        rsp_ff, rsp_in;

   logic                        read_en;
   logic                        insert;
   logic                        hit;
   logic                        added;
   logic [pib_pkg::ADDR_W-1:0]  index_val;

   always_comb begin
      hit       = rd_valid_ff && (rd_data_ff == color_ff);
      read_en   = cmd.scan && (scan_addr_ff < count_ff);

      color_in     = color_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      scan_addr_in = scan_addr_ff;
      rd_valid_in  = rd_valid_ff;
      insert       = 1'b0;
      added        = 1'b0;
      index_val    = '0;

      if (cmd.start) begin
         color_in     = {req_data.red, req_data.green, req_data.blue};
         scan_addr_in = '0;
         rd_valid_in  = 1'b0;
         if (req_data.first_pixel) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end else if (cmd.scan) begin
         // One entry is read per cycle; its compare follows in the next cycle.
         rd_valid_in = read_en;
         if (read_en) begin
            scan_addr_in = scan_addr_ff + pib_pkg::CNT_W'(1);
         end
      end else if (cmd.finish) begin
         rd_valid_in = 1'b0;
         if (ovf_ff) begin
            index_val = '0;
         end else if (hit) begin
            index_val = rd_idx_ff;
         end else if (count_ff < pib_pkg::FULL_COUNT) begin
            insert    = 1'b1;
            added     = 1'b1;
            index_val = count_ff[pib_pkg::ADDR_W-1:0];
            count_in  = count_ff + pib_pkg::CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      rsp_in.color_index    = pib_pkg::INDEX_W'(index_val);
      rsp_in.new_entry      = added;
      rsp_in.entries_used   = pib_pkg::USED_W'(count_in);
      rsp_in.palette_usable = !ovf_in && (count_in < pib_pkg::FULL_COUNT);
   end

   // Palette memory: one write port for appends, one registered read port.
   always_ff @(posedge clock) begin
      if (insert) begin
         palette_mem[count_ff[pib_pkg::ADDR_W-1:0]] <= color_ff;
      end
      if (read_en) begin
         rd_data_ff <= palette_mem[scan_addr_ff[pib_pkg::ADDR_W-1:0]];
         rd_idx_ff  <= scan_addr_ff[pib_pkg::ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.overflowed = ovf_ff;
   assign status.hit        = hit;
   assign status.exhausted  = !rd_valid_ff && (scan_addr_ff == count_ff);
   assign rsp_data          = rsp_ff;

endmodule

[rtl/core/palette_index_builder.sv]
// Top level of the palette index builder: joins the sequencer and the datapath.
// Depends on pib_pkg, pib_ctrl and pib_datapath.

// The block takes one pixel word at a time and returns one result word for it.
// A pixel is looked up by scanning the palette memory through its single read
// port, one entry per cycle, so the time per pixel grows with the palette; the
// scan stops at a hit and ends at once with an empty palette or after overflow.
// The next pixel is taken as soon as the current result sits in the output
// register, even if that word has not yet been taken. The palette memory needs
// no clearing after reset.

module palette_index_builder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pib_pkg::pib_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pib_pkg::pib_rsp_type rsp_data
);

   pib_pkg::pib_cmd_type    cmd;
   pib_pkg::pib_status_type status;

   pib_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pib_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // Only one pixel is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pixel accepted while another is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entries_used <= pib_pkg::USED_W'(pib_pkg::PALETTE_ENTRIES))
      else $error("entry count beyond palette size");

   // An appended entry always takes the last index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_entry |->
         rsp_data.color_index ==
            pib_pkg::INDEX_W'(rsp_data.entries_used - pib_pkg::USED_W'(1)))
      else $error("new entry index does not match entry count");

   // Unusable with room left can only mean overflow, which gives index zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.palette_usable &&
         rsp_data.entries_used < pib_pkg::USED_W'(pib_pkg::PALETTE_ENTRIES) |->
         rsp_data.color_index == '0 && !rsp_data.new_entry)
      else $error("overflowed result carries an index");

endmodule
